>>> rtl/core/tafs_pkg.sv
`default_nettype none

package tafs_pkg;

  // Default width of one edge length on the input stream.
  localparam int unsigned LENGTH_WIDTH_DEFAULT = 16;

  // Result field and the stream word that carries it.
  localparam int unsigned AREA_WIDTH       = 31;
  localparam int unsigned AREA_TDATA_WIDTH = 32;
  localparam logic [AREA_WIDTH-1:0] AREA_MAX = {AREA_WIDTH{1'b1}};

  // Number of root bits (one per square root cell) for a given edge width.
  // The Heron product is below 2**(4*len_w+3), so its root fits 2*len_w+2 bits.
  function automatic int unsigned root_width(input int unsigned len_w);
    return 2 * len_w + 2;
  endfunction

  // Partial remainder width carried between square root cells.
  function automatic int unsigned rem_width(input int unsigned len_w);
    return root_width(len_w) + 1;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/tafs_front.sv
`default_nettype none

module tafs_front #(
  parameter int unsigned LENGTH_WIDTH = tafs_pkg::LENGTH_WIDTH_DEFAULT
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              in_valid,
  output logic                                              in_ready,
  input  logic [LENGTH_WIDTH-1:0]                           side_a,
  input  logic [LENGTH_WIDTH-1:0]                           side_b,
  input  logic [LENGTH_WIDTH-1:0]                           side_c,
  output logic                                              out_valid,
  input  logic                                              out_ready,
  output logic [2*tafs_pkg::root_width(LENGTH_WIDTH)-1:0]   radicand
);
  import tafs_pkg::*;

  localparam int unsigned L     = LENGTH_WIDTH;
  localparam int unsigned H     = L + 1;
  localparam int unsigned RAD_W = 2 * root_width(L);

  // Stage valid bits and per-stage advance strobes.
  logic [3:0] stage_valid;
  logic [3:0] adv;

  always_comb begin
    adv[3] = !stage_valid[3] || out_ready;
    adv[2] = !stage_valid[2] || adv[3];
    adv[1] = !stage_valid[1] || adv[2];
    adv[0] = !stage_valid[0] || adv[1];
  end

  assign in_ready  = adv[0];
  assign out_valid = stage_valid[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (adv[0]) stage_valid[0] <= in_valid;
      if (adv[1]) stage_valid[1] <= stage_valid[0];
      if (adv[2]) stage_valid[2] <= stage_valid[1];
      if (adv[3]) stage_valid[3] <= stage_valid[2];
    end
  end

  // Sorting network and Kahan sums.
  logic [L-1:0]   hi1, lo1, mid1, a_s, b_s, c_s;
  logic [L:0]     sum_bc;
  logic           fits;
  logic [L+1:0]   s1_next;
  logic [L-1:0]   s2_next, s3_next;
  logic [L:0]     s4_next;

  always_comb begin
    hi1  = (side_a < side_b) ? side_b : side_a;
    lo1  = (side_a < side_b) ? side_a : side_b;
    mid1 = (lo1 < side_c) ? side_c : lo1;
    c_s  = (lo1 < side_c) ? lo1 : side_c;
    a_s  = (hi1 < mid1) ? mid1 : hi1;
    b_s  = (hi1 < mid1) ? hi1 : mid1;

    sum_bc  = {1'b0, b_s} + {1'b0, c_s};
    fits    = sum_bc > {1'b0, a_s};
    s1_next = (L+2)'(sum_bc) + (L+2)'(a_s);
    // A degenerate triangle gets a zero factor, so its product and area are zero.
    s2_next = fits ? L'(sum_bc - {1'b0, a_s}) : '0;
    s3_next = c_s + (a_s - b_s);
    s4_next = (L+1)'(a_s) + (L+1)'(b_s - c_s);
  end

  logic [L+1:0]   s1;
  logic [L-1:0]   s2, s3;
  logic [L:0]     s4;
  logic [2*H-1:0] p12, p34;
  logic [2*H-1:0] pp_ll, pp_lh, pp_hl, pp_hh;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
      s4 <= s4_next;
    end
    if (adv[1]) begin
      p12 <= (2*H)'(s1) * (2*H)'(s2);
      p34 <= (2*H)'(s3) * (2*H)'(s4);
    end
    // The final product is split into four half-width partial products.
    if (adv[2]) begin
      pp_ll <= (2*H)'(p12[H-1:0])   * (2*H)'(p34[H-1:0]);
      pp_lh <= (2*H)'(p12[H-1:0])   * (2*H)'(p34[2*H-1:H]);
      pp_hl <= (2*H)'(p12[2*H-1:H]) * (2*H)'(p34[H-1:0]);
      pp_hh <= (2*H)'(p12[2*H-1:H]) * (2*H)'(p34[2*H-1:H]);
    end
    if (adv[3]) begin
      radicand <= {pp_hh, pp_ll}
                + (RAD_W'((2*H+1)'(pp_lh) + (2*H+1)'(pp_hl)) << H);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tafs_root_cell.sv
`default_nettype none

module tafs_root_cell #(
  parameter int unsigned LENGTH_WIDTH = tafs_pkg::LENGTH_WIDTH_DEFAULT
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             in_valid,
  output logic                                             in_ready,
  input  logic [tafs_pkg::rem_width(LENGTH_WIDTH)-1:0]     in_rem,
  input  logic [tafs_pkg::root_width(LENGTH_WIDTH)-1:0]    in_root,
  input  logic [2*tafs_pkg::root_width(LENGTH_WIDTH)-1:0]  in_rad,
  output logic                                             out_valid,
  input  logic                                             out_ready,
  output logic [tafs_pkg::rem_width(LENGTH_WIDTH)-1:0]     out_rem,
  output logic [tafs_pkg::root_width(LENGTH_WIDTH)-1:0]    out_root,
  output logic [2*tafs_pkg::root_width(LENGTH_WIDTH)-1:0]  out_rad
);
  import tafs_pkg::*;

  localparam int unsigned R     = root_width(LENGTH_WIDTH);
  localparam int unsigned REM_W = rem_width(LENGTH_WIDTH);

  // One restoring square root step: bring down two radicand bits and try
  // to append a one to the root.
  logic [REM_W+1:0] rem_shift;
  logic [REM_W+1:0] trial;
  logic             take;

  always_comb begin
    rem_shift = {in_rem, in_rad[2*R-1 -: 2]};
    trial     = (REM_W+2)'({in_root, 2'b01});
    take      = rem_shift >= trial;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_rem  <= take ? REM_W'(rem_shift - trial) : REM_W'(rem_shift);
      out_root <= {in_root[R-2:0], take};
      out_rad  <= {in_rad[2*R-3:0], 2'b00};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/triangle_area_from_sides_unit.sv
// From an accepted request to its area the path is: four front stages, one square
// root cell per root bit, one output register.
// Throughput: one request per cycle unless the output stalls; every stage and cell holds its own item.
// Reset (rst, synchronous, active high) clears all valid bits; data registers are not reset.
`default_nettype none

module triangle_area_from_sides_unit #(
  parameter int unsigned LENGTH_WIDTH = tafs_pkg::LENGTH_WIDTH_DEFAULT
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           s_axis_tvalid,
  output logic                                           s_axis_tready,
  // Fields from bit 0 up: side_a, side_b, side_c, zero padding to a whole byte.
  input  logic [((3*LENGTH_WIDTH+7)/8)*8-1:0]            s_axis_tdata,
  output logic                                           m_axis_tvalid,
  input  logic                                           m_axis_tready,
  // Fields from bit 0 up: area (Q15.16), one zero pad bit.
  output logic [tafs_pkg::AREA_TDATA_WIDTH-1:0]          m_axis_tdata
);
  import tafs_pkg::*;

  localparam int unsigned L     = LENGTH_WIDTH;
  localparam int unsigned R     = root_width(L);
  localparam int unsigned REM_W = rem_width(L);

  // The front sorts the sides, forms the four Kahan factors and multiplies
  // them out into the exact Heron product, which is 16 times the squared area.
  logic             front_valid;
  logic [2*R-1:0]   front_rad;

  // Handshake and data of the cell chain; entry 0 is the front's output,
  // entry i is the output of cell i-1.
  logic [R:0]       chain_valid;
  logic [R:0]       chain_ready;
  logic [REM_W-1:0] chain_rem  [R+1];
  logic [R-1:0]     chain_root [R+1];
  logic [2*R-1:0]   chain_rad  [R+1];

  tafs_front #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .side_a    (s_axis_tdata[L-1:0]),
    .side_b    (s_axis_tdata[2*L-1:L]),
    .side_c    (s_axis_tdata[3*L-1:2*L]),
    .out_valid (front_valid),
    .out_ready (chain_ready[0]),
    .radicand  (front_rad)
  );

  assign chain_valid[0] = front_valid;
  assign chain_rem[0]   = '0;
  assign chain_root[0]  = '0;
  assign chain_rad[0]   = front_rad;

  // The square root is a row of identical cells, each settling one root bit,
  // most significant first, and passing remainder, partial root and the rest
  // of the radicand on to its neighbor.
  for (genvar i = 0; i < R; i++) begin : g_cell
    tafs_root_cell #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_rem    (chain_rem[i]),
      .in_root   (chain_root[i]),
      .in_rad    (chain_rad[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_rem   (chain_rem[i+1]),
      .out_root  (chain_root[i+1]),
      .out_rad   (chain_rad[i+1])
    );
  end

  // The root is four times the area, so two bits are dropped. Only wide edge
  // widths can exceed the result field; the area then saturates.
  logic [2*L-1:0]        root_quarter;
  logic [AREA_WIDTH-1:0] area_next;

  assign root_quarter = chain_root[R][R-1:2];

  if (2 * L > AREA_WIDTH) begin : g_sat
    assign area_next = (|root_quarter[2*L-1:AREA_WIDTH]) ? AREA_MAX
                                                         : root_quarter[AREA_WIDTH-1:0];
  end else begin : g_nosat
    assign area_next = AREA_WIDTH'(root_quarter);
  end

  // Output register: it parts the result side from the chain, so new
  // requests keep entering while bubbles remain ahead of a stalled result.
  logic                  area_valid;
  logic [AREA_WIDTH-1:0] area;

  assign chain_ready[R] = !area_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_valid <= 1'b0;
    end else if (chain_ready[R]) begin
      area_valid <= chain_valid[R];
    end
  end

  always_ff @(posedge clk) begin
    if (chain_ready[R]) begin
      area <= area_next;
    end
  end

  assign m_axis_tvalid = area_valid;
  assign m_axis_tdata  = {{(AREA_TDATA_WIDTH - AREA_WIDTH){1'b0}}, area};

  // A consumer that is ready frees every stage, so the input side must be ready too.
  a_ready_chain : assert property (@(posedge clk) m_axis_tready |-> s_axis_tready)
    else $error("input not ready although the result side is ready");

  // Nothing leaves the block in the cycle after a reset.
  a_reset_empty : assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // An item leaving the front enters the first cell when that cell has room.
  a_front_to_cell : assert property (@(posedge clk) disable iff (rst)
    front_valid && chain_ready[0] |=> chain_valid[1])
    else $error("item from the front lost at the first root cell");

endmodule

`default_nettype wire

>>> tb/sv/tb_triangle_area_from_sides_unit.sv
module tb_triangle_area_from_sides_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Self-checking bench for the triangle area unit.
  // Each request carries three Q8.8 edge lengths; the unit answers with one Q15.16 area.
  // The bench keeps its own model of the area so that every response can be checked.
  // That model sorts the sides, forms the four Kahan terms and takes an exact integer
  // square root.

  import tafs_pkg::*;

  localparam int unsigned SIDE_W       = LENGTH_WIDTH_DEFAULT;
  localparam int unsigned IN_TDATA_W   = ((3 * SIDE_W + 7) / 8) * 8;
  // Pipeline depth of the unit: front stages, root cells and output register.
  localparam int unsigned LATENCY      = 2 * SIDE_W + 7;
  localparam int unsigned TAIL_CYCLES  = LATENCY + 10;
  localparam int unsigned RANDOM_PER_PHASE  = 176;
  localparam int unsigned LONG_STALL_CYCLES = 150;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned DIRECTED_ROWS = 22;

  typedef logic [SIDE_W-1:0]     side_t;
  typedef logic [AREA_WIDTH-1:0] area_t;

  // One directed request. When known is set, the expected area is the one typed
  // in the row; otherwise the area model supplies it.
  typedef struct packed {
    side_t a;
    side_t b;
    side_t c;
    logic  known;
    area_t area;
  } directed_row_t;

  // An accepted request whose area has not been seen yet.
  typedef struct packed {
    side_t a;
    side_t b;
    side_t c;
    area_t area;
  } area_expect_t;

  // 6.0 in Q15.16, the area of a 3-4-5 right triangle.
  localparam area_t AREA_SIX = area_t'(32'h0006_0000);

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  // Fields from bit 0 up: side_a, side_b, side_c.
  logic [IN_TDATA_W-1:0]         s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  // Fields from bit 0 up: area (Q15.16), one zero pad bit.
  logic [AREA_TDATA_WIDTH-1:0]   m_axis_tdata;

  area_expect_t pending_areas[$];
  area_expect_t head_area;

  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  int unsigned stall_requests;
  int unsigned stalls_served;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned requests_sent;
  int unsigned areas_checked;
  int unsigned zero_areas;
  int unsigned input_stall_cycles;

  // The directed part: the corners of the side range, degenerate and impossible
  // triangles, and the 3-4-5 triangle in every order so that each path of the
  // sorting network is taken.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{16'h0000, 16'h0000, 16'h0000, 1'b1, '0},
    '{16'h0000, 16'h0000, 16'hFFFF, 1'b1, '0},
    '{16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, '0},
    '{16'h0300, 16'h0200, 16'h0100, 1'b1, '0},
    '{16'h0100, 16'h0300, 16'h0100, 1'b1, '0},
    '{16'h0300, 16'h0400, 16'h0500, 1'b1, AREA_SIX},
    '{16'h0300, 16'h0500, 16'h0400, 1'b1, AREA_SIX},
    '{16'h0400, 16'h0300, 16'h0500, 1'b1, AREA_SIX},
    '{16'h0400, 16'h0500, 16'h0300, 1'b1, AREA_SIX},
    '{16'h0500, 16'h0300, 16'h0400, 1'b1, AREA_SIX},
    '{16'h0500, 16'h0400, 16'h0300, 1'b1, AREA_SIX},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0},
    '{16'hFFFF, 16'hFFFF, 16'h0001, 1'b0, '0},
    '{16'hAAAA, 16'h5555, 16'h5555, 1'b1, '0},
    '{16'h5555, 16'hAAAA, 16'hFFFF, 1'b1, '0},
    '{16'h0001, 16'h0001, 16'h0001, 1'b0, '0},
    '{16'h8000, 16'h8000, 16'h8000, 1'b0, '0},
    '{16'hFFFF, 16'h8000, 16'h8000, 1'b0, '0},
    '{16'h0005, 16'h0005, 16'h0009, 1'b0, '0},
    '{16'h1234, 16'h0FED, 16'h0ABC, 1'b0, '0},
    '{16'h0001, 16'hFFFF, 16'hFFFF, 1'b0, '0},
    '{16'h00FF, 16'h0100, 16'hFF00, 1'b0, '0}
  };

  triangle_area_from_sides_unit #(
    .LENGTH_WIDTH(SIDE_W)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Area model. The sides are put in descending order, the triangle test is
  // b + c > a, and the product of the four Kahan terms is exact in 128 bits.
  // The root is found one bit at a time from the top, then divided by four.
  function automatic area_t heron_area(input side_t sa, input side_t sb, input side_t sc);
    logic [63:0]  big_s, mid_s, low_s, swap;
    logic [63:0]  sum_all, diff_bc, diff_ab, sum_bc;
    logic [127:0] heron_prod, cand_sq;
    logic [63:0]  root, cand;
    big_s = 64'(sa);
    mid_s = 64'(sb);
    low_s = 64'(sc);
    if (big_s < mid_s) begin
      swap = big_s; big_s = mid_s; mid_s = swap;
    end
    if (mid_s < low_s) begin
      swap = mid_s; mid_s = low_s; low_s = swap;
    end
    if (big_s < mid_s) begin
      swap = big_s; big_s = mid_s; mid_s = swap;
    end
    // Degenerate or impossible triangles have no positive product.
    if (mid_s + low_s <= big_s) begin
      return '0;
    end
    sum_all = big_s + mid_s + low_s;
    diff_bc = (mid_s + low_s) - big_s;
    diff_ab = low_s + (big_s - mid_s);
    sum_bc  = big_s + (mid_s - low_s);
    heron_prod = {64'd0, sum_all * diff_bc} * {64'd0, diff_ab * sum_bc};
    root = '0;
    for (int pos = 60; pos >= 0; pos--) begin
      cand    = root | (64'd1 << pos);
      cand_sq = {64'd0, cand} * {64'd0, cand};
      if (cand_sq <= heron_prod) begin
        root = cand;
      end
    end
    root = root >> 2;
    if (root > 64'(AREA_MAX)) begin
      return AREA_MAX;
    end
    return root[AREA_WIDTH-1:0];
  endfunction

  // Offers one request, with random idle cycles in front of it as the current
  // phase asks. The request is held until the unit takes it; tready is looked
  // at on the falling edge, where both sides of the handshake are settled for
  // the rising edge that follows. On return the valid stays high, so that a
  // request that comes straight after can follow without a gap.
  task automatic push_request(input side_t a, input side_t b, input side_t c,
                              input logic known, input area_t typed_area);
    area_expect_t entry;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c, b, a};
    do begin
      @(negedge clk);
    end while (!s_axis_tready);
    @(posedge clk);
    entry.a    = a;
    entry.b    = b;
    entry.c    = c;
    entry.area = known ? typed_area : heron_area(a, b, c);
    if (entry.area == '0) begin
      zero_areas++;
    end
    pending_areas.insert(pending_areas.size(), entry);
    requests_sent++;
  endtask

  // Random triangles. Most are real triangles with the third side drawn between
  // the difference and the sum of the other two; the rest are small sides,
  // flat triangles with one side the sum of the others, and plain random words.
  // The order is shuffled so the sorting network sees every arrangement.
  task automatic push_random_triangle();
    int unsigned x, y, z, lo, hi, kind, swap;
    kind = $urandom_range(99);
    if (kind < 60) begin
      x  = $urandom_range(65535, 1);
      y  = $urandom_range(65535, 1);
      lo = ((x > y) ? x - y : y - x) + 1;
      hi = x + y - 1;
      if (hi > 65535) begin
        hi = 65535;
      end
      z = (lo <= hi) ? $urandom_range(hi, lo) : lo - 1;
    end else if (kind < 70) begin
      x = $urandom_range(15);
      y = $urandom_range(15);
      z = $urandom_range(15);
    end else if (kind < 80) begin
      x = $urandom_range(65535);
      y = $urandom_range(65535 - x);
      z = x + y;
    end else begin
      x = $urandom_range(65535);
      y = $urandom_range(65535);
      z = $urandom_range(65535);
    end
    if ($urandom_range(1)) begin
      swap = x; x = y; y = swap;
    end
    if ($urandom_range(1)) begin
      swap = y; y = z; z = swap;
    end
    if ($urandom_range(1)) begin
      swap = x; x = z; z = swap;
    end
    push_request(side_t'(x), side_t'(y), side_t'(z), 1'b0, '0);
  endtask

  // The sender stops offering and waits until every area it asked for is back.
  task automatic wait_for_all_areas();
    s_axis_tvalid <= 1'b0;
    while (pending_areas.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Response side. A long hold-off is asked for by bumping stall_requests; the
  // count of cycles is kept here, so the sender can keep pushing meanwhile.
  initial begin
    m_axis_tready = 1'b0;
    stalls_served = 0;
    hold_left     = 0;
    forever begin
      @(posedge clk);
      if (stall_requests != stalls_served) begin
        stalls_served++;
        hold_left = LONG_STALL_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // Response checker and input stall counter, sampled on the falling edge ahead of the accepting edge.
  always @(negedge clk) begin
    if (!rst && s_axis_tvalid && !s_axis_tready) begin
      input_stall_cycles++;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_areas.size() == 0) begin
        error_count++;
        $display("%0t: area %0d arrived with no request waiting for it", $time,
                 m_axis_tdata[AREA_WIDTH-1:0]);
      end else begin
        head_area = pending_areas.pop_front();
        areas_checked++;
        if (m_axis_tdata[AREA_WIDTH-1:0] !== head_area.area) begin
          error_count++;
          $display("%0t: area mismatch for sides %h %h %h: expected %0d, actual %0d",
                   $time, head_area.a, head_area.b, head_area.c, head_area.area,
                   m_axis_tdata[AREA_WIDTH-1:0]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Run stopped after %0d cycles with %0d areas still outstanding", cycle_count,
             pending_areas.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst                = 1'b1;
    s_axis_tvalid      = 1'b0;
    s_axis_tdata       = '0;
    requests_sent      = 0;
    zero_areas         = 0;
    stall_requests     = 0;
    sender_idle_pct    = 23;
    receiver_idle_pct  = 75;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests run under the first idling pattern.
    for (int row = 0; row < DIRECTED_ROWS; row++) begin
      push_request(directed_rows[row].a, directed_rows[row].b, directed_rows[row].c,
                   directed_rows[row].known, directed_rows[row].area);
    end

    // Three random phases: a slow receiver, then a slow sender, then both at
    // full rate. The last phase opens with a long receiver hold-off while
    // requests keep coming, so the pipeline fills and the input has to stall.
    // Between phases the sender waits until every area has come back.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct   = 23;
          receiver_idle_pct = 75;
        end
        1: begin
          sender_idle_pct   = 75;
          receiver_idle_pct = 23;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
          stall_requests++;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        push_random_triangle();
      end
      wait_for_all_areas();
    end

    // Anything that shows up now has no request behind it and is flagged.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d side triples (%0d directed), checked %0d areas, %0d of them zero.",
             requests_sent, DIRECTED_ROWS, areas_checked, zero_areas);
    $display("The input was held off for %0d cycles; %0d mismatches were found.",
             input_stall_cycles, error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/tafs_pkg.sv
rtl/core/tafs_front.sv
rtl/core/tafs_root_cell.sv
rtl/core/triangle_area_from_sides_unit.sv
tb/sv/tb_triangle_area_from_sides_unit.sv
